>>> src/adjacency_matrix_dfs_defines.svh
// Assertion macros for the adjacency matrix depth-first search block.
`ifndef ADJACENCY_MATRIX_DFS_DEFINES_SVH
`define ADJACENCY_MATRIX_DFS_DEFINES_SVH
`ifndef ASSERT_OFF
`define AMD_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define AMD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define AMD_ASSERT_IMPL(label, clk, rst_n, prop)
`define AMD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> src/amd_pkg.sv
// Package with types and constants for the adjacency matrix depth-first search block.
package amd_pkg;
  localparam int MaxVerts = 16;
  localparam int IdxW = $clog2(MaxVerts);
  localparam int CntW = $clog2(MaxVerts + 1);
  localparam int ResCap = 16;
  localparam int ResW = $clog2(ResCap + 1);

  localparam logic [1:0] REQ_ADD_VERTEX = 2'd0;
  localparam logic [1:0] REQ_ADD_EDGE = 2'd1;
  localparam logic [1:0] REQ_WALK = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EXISTS = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic signed [15:0] vertex_a;
    logic signed [15:0] vertex_b;
    logic signed [15:0] edge_weight;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] visited_label;
    logic last_result;
    logic [1:0] status;
  } out_word_t;
endpackage

>>> src/amd_ram.sv
// Generic single-port RAM with registered read data.
module amd_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> src/adjacency_matrix_dfs.sv
// Top level: graph store with add vertex, add edge and depth-first walk.
// Add vertex and unused codes answer in the cycle after start; add edge may pass S_EDGE.
// A walk holds busy through S_READ and S_SCAN; its last word comes in the cycle busy falls.
// The matrix lives in one RAM, one row per word, read once per step.
// After reset a clearing pass zeroes all MaxVerts matrix rows; busy is high meanwhile.
// Results are one-cycle strobes; the receiver cannot stall.
`include "adjacency_matrix_dfs_defines.svh"
module adjacency_matrix_dfs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  amd_pkg::in_word_t in_word,
  output logic              out_valid,
  output amd_pkg::out_word_t out_word
);
  import amd_pkg::*;

  localparam int RowW = 16 * MaxVerts;
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EDGE = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [IdxW-1:0] clr_r, clr_nxt;
  logic [CntW-1:0] vcount_r, vcount_nxt;
  logic signed [15:0] labels_r [MaxVerts];
  logic [IdxW-1:0] canon_r [MaxVerts];
  logic [MaxVerts-1:0] visited_r, visited_nxt;
  logic [IdxW-1:0] stk_vert_r [MaxVerts];
  logic [CntW-1:0] stk_scan_r [MaxVerts];
  logic [CntW-1:0] depth_r, depth_nxt;
  logic [ResW-1:0] nres_r, nres_nxt;
  in_word_t req_r;
  logic [IdxW-1:0] pa_r, pb_r;
  logic out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;
  logic accept;

  logic ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [RowW-1:0] ram_wdata, ram_rdata;

  assign accept = start && !busy;

  amd_ram #(.Width(RowW), .Depth(MaxVerts)) u_matrix (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic found_a, found_b;
  logic [IdxW-1:0] idx_a, idx_b;
  always_comb begin
    found_a = 1'b0;
    found_b = 1'b0;
    idx_a = '0;
    idx_b = '0;
    for (int i = MaxVerts - 1; i >= 0; i--) begin
      if (CntW'(i) < vcount_r && labels_r[i] == in_word.vertex_a) begin
        found_a = 1'b1;
        idx_a = IdxW'(i);
      end
      if (CntW'(i) < vcount_r && labels_r[i] == in_word.vertex_b) begin
        found_b = 1'b1;
        idx_b = IdxW'(i);
      end
    end
  end

  logic [IdxW-1:0] top_idx;
  logic [CntW-1:0] top_scan;
  logic hit;
  logic [IdxW-1:0] hit_i;
  assign top_idx = (depth_r == '0) ? '0 : IdxW'(depth_r - 1'b1);
  assign top_scan = stk_scan_r[top_idx];
  always_comb begin
    hit = 1'b0;
    hit_i = '0;
    for (int i = MaxVerts - 1; i >= 0; i--) begin
      if (CntW'(i) >= top_scan && CntW'(i) < vcount_r
          && ram_rdata[16*i +: 16] != 16'd0 && !visited_r[canon_r[i]]) begin
        hit = 1'b1;
        hit_i = IdxW'(i);
      end
    end
  end

  logic [IdxW-1:0] q;
  assign q = canon_r[hit_i];

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    vcount_nxt = vcount_r;
    visited_nxt = visited_r;
    depth_nxt = depth_r;
    nres_nxt = nres_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    ram_we = 1'b0;
    ram_addr = '0;
    ram_wdata = ram_rdata;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
        ram_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IdxW'(MaxVerts - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_addr = idx_a;
        if (accept) begin
          out_nxt = '{visited_label: '0, last_result: 1'b1, status: ST_OK};
          case (in_word.req_type)
            REQ_ADD_VERTEX: begin
              out_valid_nxt = 1'b1;
              if (vcount_r >= CntW'(MaxVerts)) begin
                out_nxt.status = ST_FULL;
              end else begin
                vcount_nxt = vcount_r + 1'b1;
              end
            end
            REQ_ADD_EDGE: begin
              if (!found_a || !found_b) begin
                out_valid_nxt = 1'b1;
                out_nxt.status = ST_NOT_FOUND;
              end else begin
                state_nxt = S_EDGE;
              end
            end
            REQ_WALK: begin
              visited_nxt = '0;
              if (!found_a) begin
                out_valid_nxt = 1'b1;
                out_nxt.status = ST_NOT_FOUND;
              end else begin
                visited_nxt[idx_a] = 1'b1;
                out_valid_nxt = 1'b1;
                out_nxt.visited_label = labels_r[idx_a];
                out_nxt.last_result = 1'b0;
                depth_nxt = CntW'(1);
                nres_nxt = ResW'(1);
                state_nxt = S_SCAN;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_EDGE: begin
        ram_addr = pa_r;
        out_valid_nxt = 1'b1;
        out_nxt = '{visited_label: '0, last_result: 1'b1, status: ST_OK};
        if (ram_rdata[16*pb_r +: 16] != 16'd0) begin
          out_nxt.status = ST_EXISTS;
        end else begin
          ram_we = 1'b1;
          ram_wdata[16*pb_r +: 16] = req_r.edge_weight;
        end
        state_nxt = S_IDLE;
      end
      S_READ: begin
        ram_addr = stk_vert_r[top_idx];
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        ram_addr = stk_vert_r[top_idx];
        if (hit) begin
          visited_nxt[q] = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt = '{visited_label: labels_r[q], last_result: 1'b0, status: ST_OK};
          nres_nxt = nres_r + 1'b1;
          if (depth_r < CntW'(MaxVerts)) begin
            depth_nxt = depth_r + 1'b1;
          end
          if (nres_r + 1'b1 == ResW'(ResCap)) begin
            out_nxt.last_result = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
          end
        end else begin
          depth_nxt = depth_r - 1'b1;
          if (depth_r == CntW'(1)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt = '{visited_label: '0, last_result: 1'b1, status: ST_OK};
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A walk that ends by backtracking marks its last visited label; hold one result back.
  out_word_t held_r, held_nxt;
  logic held_v_r, held_v_nxt;
  logic emit_v;
  out_word_t emit_w;
  always_comb begin
    held_nxt = held_r;
    held_v_nxt = held_v_r;
    emit_v = 1'b0;
    emit_w = held_r;
    if (state_r == S_DONE) begin
      emit_v = held_v_r;
      emit_w = held_r;
      emit_w.last_result = 1'b1;
      held_v_nxt = 1'b0;
    end else if (out_valid_nxt && !out_nxt.last_result) begin
      emit_v = held_v_r;
      held_nxt = out_nxt;
      held_v_nxt = 1'b1;
    end else if (out_valid_nxt) begin
      emit_v = 1'b1;
      emit_w = out_nxt;
      if (held_v_r) begin
        emit_w = held_r;
        held_nxt = out_nxt;
        held_v_nxt = 1'b1;
      end
    end else if (held_v_r && state_r == S_IDLE) begin
      emit_v = 1'b1;
      held_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      vcount_r <= '0;
      visited_r <= '0;
      depth_r <= '0;
      nres_r <= '0;
      out_valid_r <= 1'b0;
      held_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      vcount_r <= vcount_nxt;
      visited_r <= visited_nxt;
      depth_r <= depth_nxt;
      nres_r <= nres_nxt;
      out_valid_r <= emit_v;
      held_v_r <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    held_r <= held_nxt;
    out_word <= emit_w;
    if (state_r == S_IDLE && accept) begin
      req_r <= in_word;
      pa_r <= idx_a;
      pb_r <= idx_b;
      if (in_word.req_type == REQ_ADD_VERTEX && vcount_r < CntW'(MaxVerts)) begin
        labels_r[IdxW'(vcount_r)] <= in_word.vertex_a;
        canon_r[IdxW'(vcount_r)] <= found_a ? idx_a : IdxW'(vcount_r);
      end
      if (in_word.req_type == REQ_WALK) begin
        stk_vert_r[0] <= idx_a;
        stk_scan_r[0] <= '0;
      end
    end
    if (state_r == S_SCAN && hit) begin
      stk_scan_r[top_idx] <= CntW'(hit_i) + 1'b1;
      if (depth_r < CntW'(MaxVerts)) begin
        stk_vert_r[IdxW'(depth_r)] <= q;
        stk_scan_r[IdxW'(depth_r)] <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign busy = (state_r != S_IDLE) || held_v_r;

  `AMD_ASSERT_IMPL(a_count_bound, clk, rst_n, vcount_r <= CntW'(MaxVerts))
  `AMD_ASSERT_IMPL(a_start_ok, clk, rst_n, (start && !busy) |=> (state_r != S_CLEAR))
  `AMD_ASSERT_NEVER(a_depth_zero_scan, clk, rst_n, state_r == S_SCAN && depth_r == '0)
endmodule

>>> test/tb_adjacency_matrix_dfs.sv
// Testbench for the adjacency matrix depth-first search block: random graphs checked by a predictor.
`timescale 1ns / 1ps
module tb_adjacency_matrix_dfs;
  import amd_pkg::*;

  class graph_scoreboard;
    logic [15:0] labels[MaxVerts];
    int unsigned nverts;
    logic [15:0] weights[MaxVerts][MaxVerts];
    out_word_t pending[$];
    int errors;

    function new();
      nverts = 0;
      errors = 0;
      foreach (weights[i, j]) weights[i][j] = '0;
    endfunction

    function bit lookup(logic [15:0] lab, output int unsigned pos);
      pos = 0;
      for (int unsigned i = 0; i < nverts; i++) begin
        if (labels[i] == lab) begin
          pos = i;
          return 1;
        end
      end
      return 0;
    endfunction

    function void push_word(logic [15:0] lab, logic last, logic [1:0] st);
      out_word_t w;
      w.visited_label = lab;
      w.last_result = last;
      w.status = st;
      pending.insert(pending.size(), w);
    endfunction

    function void walk_from(logic [15:0] start_lab);
      bit seen[MaxVerts];
      int unsigned vstack[MaxVerts];
      int unsigned sstack[MaxVerts];
      int unsigned depth, s, p, i, q, n;
      out_word_t tail;
      foreach (seen[k]) seen[k] = 0;
      if (!lookup(start_lab, s)) begin
        push_word('0, 1'b1, ST_NOT_FOUND);
        return;
      end
      seen[s] = 1;
      push_word(labels[s], 1'b0, ST_OK);
      n = 1;
      vstack[0] = s;
      sstack[0] = 0;
      depth = 1;
      while (depth > 0 && n < ResCap) begin
        p = vstack[depth - 1];
        i = sstack[depth - 1];
        q = 0;
        while (i < nverts) begin
          if (weights[p][i] != 0 && lookup(labels[i], q) && !seen[q]) break;
          i++;
        end
        if (i >= nverts) begin
          depth--;
          continue;
        end
        sstack[depth - 1] = i + 1;
        seen[q] = 1;
        push_word(labels[q], 1'b0, ST_OK);
        n++;
        if (depth < MaxVerts) begin
          vstack[depth] = q;
          sstack[depth] = 0;
          depth++;
        end
      end
      tail = pending[pending.size() - 1];
      tail.last_result = 1'b1;
      pending[pending.size() - 1] = tail;
    endfunction

    function void note_request(in_word_t w);
      int unsigned pa, pb;
      case (w.req_type)
        REQ_ADD_VERTEX: begin
          if (nverts >= MaxVerts) push_word('0, 1'b1, ST_FULL);
          else begin
            labels[nverts] = w.vertex_a;
            nverts++;
            push_word('0, 1'b1, ST_OK);
          end
        end
        REQ_ADD_EDGE: begin
          if (!lookup(w.vertex_a, pa) || !lookup(w.vertex_b, pb))
            push_word('0, 1'b1, ST_NOT_FOUND);
          else if (weights[pa][pb] != 0) push_word('0, 1'b1, ST_EXISTS);
          else begin
            weights[pa][pb] = w.edge_weight;
            push_word('0, 1'b1, ST_OK);
          end
        end
        REQ_WALK: walk_from(w.vertex_a);
        default: push_word('0, 1'b1, ST_OK);
      endcase
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task automatic check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report("unexpected word", 32'(got), 0);
        return;
      end
      want = pending.pop_front();
      if (got.visited_label !== want.visited_label)
        report("visited_label", 32'(got.visited_label), 32'(want.visited_label));
      if (got.last_result !== want.last_result)
        report("last_result", 32'(got.last_result), 32'(want.last_result));
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
    endtask
  endclass

  localparam int IdleLimit = 4000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;
  graph_scoreboard sb = new();
  int idle_cycles = 0;
  logic [15:0] pool[8];

  adjacency_matrix_dfs dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_word);
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("adjacency_matrix_dfs test failed");
      $finish;
    end
  end

  task automatic send(logic [1:0] rt, logic [15:0] a, logic [15:0] b, logic [15:0] w);
    in_word_t v;
    v.req_type = rt;
    v.vertex_a = a;
    v.vertex_b = b;
    v.edge_weight = w;
    start <= 1'b1;
    in_word <= v;
    do @(posedge clk); while (busy);
    sb.note_request(v);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_label();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return pool[$urandom_range(0, 7)];
  endfunction

  task automatic random_graph(int items);
    int burst = 0;
    logic [1:0] rt;
    for (int k = 0; k < items; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 20));
      end
      burst--;
      case ($urandom_range(0, 9))
        0, 1, 2: rt = REQ_ADD_VERTEX;
        3, 4, 5, 6: rt = REQ_ADD_EDGE;
        7, 8: rt = REQ_WALK;
        default: rt = REQ_UNUSED;
      endcase
      send(rt, pick_label(), pick_label(),
           ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(REQ_WALK, 16'h0000, 16'h0, 16'h0);
    send(REQ_ADD_EDGE, 16'h8000, 16'h7fff, 16'h1);
    send(REQ_ADD_VERTEX, 16'h8000, 16'hffff, 16'hffff);
    send(REQ_ADD_VERTEX, 16'h7fff, 16'h0, 16'h0);
    send(REQ_ADD_VERTEX, 16'h8000, 16'h0, 16'h0);
    send(REQ_ADD_EDGE, 16'h8000, 16'h7fff, 16'h0);
    send(REQ_ADD_EDGE, 16'h8000, 16'h7fff, 16'h8000);
    send(REQ_ADD_EDGE, 16'h8000, 16'h7fff, 16'h7fff);
    send(REQ_ADD_EDGE, 16'h7fff, 16'h8000, 16'hffff);
    send(REQ_ADD_EDGE, 16'h1234, 16'h8000, 16'h5);
    send(REQ_WALK, 16'h8000, 16'h0, 16'h0);
    send(REQ_WALK, 16'h7fff, 16'h0, 16'h0);
    send(REQ_WALK, 16'h5555, 16'h0, 16'h0);
    send(REQ_UNUSED, 16'hffff, 16'hffff, 16'hffff);
    for (int i = 3; i < 17; i++) send(REQ_ADD_VERTEX, 16'(i), 16'h0, 16'h0);
    for (int i = 3; i < 16; i++) send(REQ_ADD_EDGE, 16'(i - 1), 16'(i), 16'h1);
    send(REQ_ADD_EDGE, 16'h7fff, 16'd2, 16'h1);
    send(REQ_WALK, 16'h8000, 16'h0, 16'h0);
    drain();
    for (int g = 0; g < 14; g++) begin
      foreach (pool[i]) pool[i] = (g % 3 == 0) ? 16'($urandom_range(0, 5)) : 16'($urandom);
      random_graph(30);
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("adjacency_matrix_dfs test passed");
    end else begin
      $display("adjacency_matrix_dfs test failed");
    end
    $finish;
  end
endmodule
